FILE: hw/rtl/tftp_pkg.sv
`default_nettype none
package tftp_pkg;
   localparam int BlockBytesDefault = 512;
   localparam logic [9:0] RxMax = 10'd580;

   localparam logic [2:0] OP_START = 3'd0;
   localparam logic [2:0] OP_PACKET = 3'd1;
   localparam logic [2:0] OP_TICK = 3'd2;
   localparam logic [2:0] OP_BLOCK = 3'd3;
   localparam logic [2:0] OP_ABORT = 3'd4;

   localparam logic [2:0] K_NONE = 3'd0;
   localparam logic [2:0] K_RRQ = 3'd1;
   localparam logic [2:0] K_WRQ = 3'd2;
   localparam logic [2:0] K_DATA = 3'd3;
   localparam logic [2:0] K_ACK = 3'd4;
   localparam logic [2:0] K_ERR = 3'd5;

   localparam logic [2:0] ACT_NONE = 3'd0;
   localparam logic [2:0] ACT_REQ = 3'd1;
   localparam logic [2:0] ACT_ACK = 3'd2;
   localparam logic [2:0] ACT_DATA = 3'd3;
   localparam logic [2:0] ACT_STRAY = 3'd4;
   localparam logic [2:0] ACT_WANT = 3'd5;
   localparam logic [2:0] ACT_RESEND = 3'd6;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_BUSY = 3'd1;
   localparam logic [2:0] ST_DONE = 3'd2;
   localparam logic [2:0] ST_TIMEOUT = 3'd3;
   localparam logic [2:0] ST_SERR = 3'd4;
   localparam logic [2:0] ST_ABORT = 3'd5;

   localparam logic [15:0] STRAY_CODE = 16'd5;
   localparam int QDepth = 2;

   typedef enum logic [6:0] {
      PH_IDLE = 7'b0000001,
      PH_WAIT = 7'b0000010,
      PH_WANT = 7'b0000100,
      PH_DONE = 7'b0001000,
      PH_TIMEOUT = 7'b0010000,
      PH_SERR = 7'b0100000,
      PH_ABORT = 7'b1000000
   } phase_type;

   // classified event passed from front to back
   typedef struct packed {
      logic [2:0] opcode;
      logic direction;
      logic [9:0] plen;
      logic len_ok;
      logic kind_data;
      logic kind_ack;
      logic kind_err;
      logic [15:0] pword;
      logic [47:0] source_id;
      logic [9:0] got;
      logic got_short;
   } event_type;

   typedef struct packed {
      logic [2:0] action;
      logic [2:0] send_kind;
      logic [15:0] send_block;
      logic to_source;
      logic [9:0] send_payload_len;
      logic [9:0] deliver_len;
      logic [2:0] status;
      logic [15:0] server_error_code;
      logic [31:0] total_bytes;
   } result_type;
endpackage
`default_nettype wire

FILE: hw/rtl/tftp_client_transfer_engine_core.sv
// TFTP client transfer engine, octet mode, get and put.
// Input channel req_*: one event per item (start, packet header, tick,
// next block ready, abort). Output channel rsp_*: exactly one result
// item per input item, in order, telling what to send next plus status.
// csr_*: register writes (0 retry limit, 1 timeout ticks, 2 server id),
// taken the cycle csr_we is high; write only while the block is idle.
// Path: an accepted item waits in the two-entry event queue, and the
// execute stage registers its result when it takes it from the queue.
// Throughput: one item per cycle while rsp_ready stays high; the state
// update of the execute stage feeds back through its own registers.
// Reset: control state and peer reload to defaults, queue empties,
// registers return to their reset values.
// Stall: the result register holds while rsp_ready is low; the queue
// keeps taking items until both entries are full, then req_ready drops.
`default_nettype none
module tftp_client_transfer_engine_core
   import tftp_pkg::*;
#(
   parameter int BLOCK_BYTES = BlockBytesDefault
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic req_valid,
   output logic req_ready,
   input wire logic [2:0] req_opcode,
   input wire logic req_direction,
   input wire logic [9:0] req_packet_len,
   input wire logic [15:0] req_packet_kind,
   input wire logic [15:0] req_packet_word,
   input wire logic [47:0] req_source_id,
   input wire logic [9:0] req_block_bytes,
   output logic rsp_valid,
   input wire logic rsp_ready,
   output logic [2:0] rsp_action,
   output logic [2:0] rsp_send_kind,
   output logic [15:0] rsp_send_block,
   output logic rsp_to_source,
   output logic [9:0] rsp_send_payload_len,
   output logic [9:0] rsp_deliver_len,
   output logic [2:0] rsp_status,
   output logic [15:0] rsp_server_error_code,
   output logic [31:0] rsp_total_bytes,
   input wire logic csr_we,
   input wire logic [1:0] csr_index,
   input wire logic [47:0] csr_wdata
);
   localparam logic [1:0] REG_RETRY = 2'd0;
   localparam logic [1:0] REG_TIMEOUT = 2'd1;
   localparam logic [1:0] REG_SERVER = 2'd2;

   logic [3:0] retry_ff;
   logic [15:0] timeout_ff;
   logic [47:0] server_ff;
   event_type ev;
   logic ev_valid, ev_ready;
   result_type rsp;

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         retry_ff <= 4'd5;
         timeout_ff <= 16'd25;
         server_ff <= 48'd69;
      end else if (csr_we) begin
         case (csr_index)
            REG_RETRY: retry_ff <= csr_wdata[3:0];
            REG_TIMEOUT: timeout_ff <= csr_wdata[15:0];
            REG_SERVER: server_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   tftp_front #(.BLOCK_BYTES(BLOCK_BYTES)) u_front (
      .clock, .reset, .req_opcode, .req_direction, .req_packet_len,
      .req_packet_kind, .req_packet_word, .req_source_id, .req_block_bytes,
      .req_valid, .req_ready, .ev, .ev_valid, .ev_ready
   );

   tftp_back #(.BLOCK_BYTES(BLOCK_BYTES)) u_back (
      .clock, .reset, .retry_limit(retry_ff), .timeout_ticks(timeout_ff),
      .server_id(server_ff), .ev, .ev_valid, .ev_ready, .rsp, .rsp_valid,
      .rsp_ready
   );

   assign rsp_action = rsp.action;
   assign rsp_send_kind = rsp.send_kind;
   assign rsp_send_block = rsp.send_block;
   assign rsp_to_source = rsp.to_source;
   assign rsp_send_payload_len = rsp.send_payload_len;
   assign rsp_deliver_len = rsp.deliver_len;
   assign rsp_status = rsp.status;
   assign rsp_server_error_code = rsp.server_error_code;
   assign rsp_total_bytes = rsp.total_bytes;
endmodule
`default_nettype wire

FILE: hw/rtl/tftp_front.sv
`default_nettype none
module tftp_front
   import tftp_pkg::*;
#(
   parameter int BLOCK_BYTES = BlockBytesDefault
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic [2:0] req_opcode,
   input wire logic req_direction,
   input wire logic [9:0] req_packet_len,
   input wire logic [15:0] req_packet_kind,
   input wire logic [15:0] req_packet_word,
   input wire logic [47:0] req_source_id,
   input wire logic [9:0] req_block_bytes,
   input wire logic req_valid,
   output logic req_ready,
   output event_type ev,
   output logic ev_valid,
   input wire logic ev_ready
);
   localparam int QW = $clog2(QDepth);
   localparam logic [16:0] BlkW = 17'(BLOCK_BYTES);

   event_type q_ff [QDepth];
   logic [QW-1:0] wr_ff, rd_ff, wr_in, rd_in;
   logic [QW:0] cnt_ff, cnt_in;
   event_type cls;
   logic push, pop;

   // classify incoming item
   always_comb begin
      cls = '0;
      cls.opcode = req_opcode;
      cls.direction = req_direction;
      cls.plen = (req_packet_len > RxMax) ? RxMax : req_packet_len;
      cls.len_ok = req_packet_len >= 10'd4;
      cls.kind_data = req_packet_kind == 16'(K_DATA);
      cls.kind_ack = req_packet_kind == 16'(K_ACK);
      cls.kind_err = req_packet_kind == 16'(K_ERR);
      cls.pword = req_packet_word;
      cls.source_id = req_source_id;
      cls.got = ({7'd0, req_block_bytes} > BlkW) ? BlkW[9:0] : req_block_bytes;
      cls.got_short = {7'd0, req_block_bytes} < BlkW;
   end

   assign req_ready = cnt_ff != (QW+1)'(QDepth);
   assign ev_valid = cnt_ff != '0;
   assign ev = q_ff[rd_ff];
   assign push = req_valid && req_ready;
   assign pop = ev_valid && ev_ready;

   always_comb begin
      wr_in = push ? QW'(wr_ff + 1'b1) : wr_ff;
      rd_in = pop ? QW'(rd_ff + 1'b1) : rd_ff;
      cnt_in = cnt_ff + (QW+1)'(push) - (QW+1)'(pop);
   end

   // queue pointers
   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff <= '0;
         rd_ff <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff <= wr_in;
         rd_ff <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         q_ff[wr_ff] <= cls;
      end
   end
endmodule
`default_nettype wire

FILE: hw/rtl/tftp_back.sv
`default_nettype none
module tftp_back
   import tftp_pkg::*;
#(
   parameter int BLOCK_BYTES = BlockBytesDefault
) (
   input wire logic clock,
   input wire logic reset,
   input wire logic [3:0] retry_limit,
   input wire logic [15:0] timeout_ticks,
   input wire logic [47:0] server_id,
   input wire event_type ev,
   input wire logic ev_valid,
   output logic ev_ready,
   output result_type rsp,
   output logic rsp_valid,
   input wire logic rsp_ready
);
   phase_type phase_ff, phase_in;
   logic is_put_ff, is_put_in, peer_known_ff, peer_known_in, final_ff, final_in;
   logic [47:0] peer_ff, peer_in;
   logic [15:0] exp_ff, exp_in, tick_ff, tick_in, lblock_ff, lblock_in;
   logic [3:0] tries_ff, tries_in;
   logic [2:0] lkind_ff, lkind_in;
   logic [9:0] llen_ff, llen_in;
   logic [31:0] total_ff, total_in;
   result_type res_ff, res_in;
   logic valid_ff, take;
   logic busy, want_ok;
   logic [15:0] exp_inc, tick_inc;
   logic [3:0] tries_inc;
   logic [9:0] pay;

   assign ev_ready = !valid_ff || rsp_ready;
   assign take = ev_valid && ev_ready;
   assign rsp = res_ff;
   assign rsp_valid = valid_ff;
   assign busy = phase_ff == PH_WAIT || phase_ff == PH_WANT;
   assign exp_inc = exp_ff + 16'd1;
   assign tick_inc = tick_ff + 16'd1;
   assign tries_inc = tries_ff + 4'd1;
   assign pay = ev.plen - 10'd4;
   assign want_ok = is_put_ff ? ev.kind_ack : ev.kind_data;

   // event execution
   always_comb begin
      phase_in = phase_ff; is_put_in = is_put_ff; peer_known_in = peer_known_ff;
      peer_in = peer_ff; exp_in = exp_ff; tries_in = tries_ff; tick_in = tick_ff;
      lkind_in = lkind_ff; lblock_in = lblock_ff; llen_in = llen_ff;
      final_in = final_ff; total_in = total_ff;
      res_in = '0;
      case (ev.opcode)
         OP_START: begin
            if (!busy) begin
               is_put_in = ev.direction;
               peer_known_in = 1'b0;
               peer_in = server_id;
               exp_in = ev.direction ? 16'd0 : 16'd1;
               tries_in = '0;
               tick_in = '0;
               lkind_in = ev.direction ? K_WRQ : K_RRQ;
               lblock_in = '0;
               llen_in = '0;
               final_in = 1'b0;
               total_in = '0;
               phase_in = PH_WAIT;
               res_in.action = ACT_REQ;
               res_in.send_kind = lkind_in;
            end
         end
         OP_PACKET: begin
            if (phase_ff == PH_WAIT) begin
               tick_in = '0;
               if (peer_known_ff && ev.source_id != peer_ff) begin
                  res_in.action = ACT_STRAY;
                  res_in.send_kind = K_ERR;
                  res_in.send_block = STRAY_CODE;
                  res_in.to_source = 1'b1;
               end else if (ev.len_ok) begin
                  if (ev.kind_err) begin
                     phase_in = PH_SERR;
                     res_in.server_error_code = ev.pword;
                  end else if (want_ok) begin
                     if (!peer_known_ff) begin
                        peer_in = ev.source_id;
                        peer_known_in = 1'b1;
                     end
                     if (ev.pword == exp_ff) begin
                        if (is_put_ff) begin
                           if (final_ff) begin
                              phase_in = PH_DONE;
                           end else begin
                              phase_in = PH_WANT;
                              res_in.action = ACT_WANT;
                           end
                        end else begin
                           res_in.deliver_len = pay;
                           total_in = total_ff + 32'(pay);
                           res_in.action = ACT_ACK;
                           res_in.send_kind = K_ACK;
                           res_in.send_block = exp_ff;
                           lkind_in = K_ACK;
                           lblock_in = exp_ff;
                           llen_in = '0;
                           if (32'(pay) < 32'(BLOCK_BYTES)) begin
                              phase_in = PH_DONE;
                           end else begin
                              exp_in = exp_inc;
                              tries_in = '0;
                           end
                        end
                     end else if (!is_put_ff) begin
                        res_in.action = ACT_ACK;
                        res_in.send_kind = K_ACK;
                        res_in.send_block = ev.pword;
                     end
                  end
               end
            end
         end
         OP_TICK: begin
            if (phase_ff == PH_WAIT) begin
               tick_in = tick_inc;
               if (tick_inc >= timeout_ticks || tick_inc == '0) begin
                  tick_in = '0;
                  tries_in = tries_inc;
                  if (tries_inc >= retry_limit || tries_inc == '0) begin
                     phase_in = PH_TIMEOUT;
                  end else begin
                     res_in.action = ACT_RESEND;
                     res_in.send_kind = lkind_ff;
                     res_in.send_block = lblock_ff;
                     res_in.send_payload_len = (lkind_ff == K_DATA) ? llen_ff : '0;
                  end
               end
            end
         end
         OP_BLOCK: begin
            if (phase_ff == PH_WANT) begin
               exp_in = exp_inc;
               lkind_in = K_DATA;
               lblock_in = exp_inc;
               llen_in = ev.got;
               total_in = total_ff + 32'(ev.got);
               final_in = ev.got_short;
               tries_in = '0;
               tick_in = '0;
               phase_in = PH_WAIT;
               res_in.action = ACT_DATA;
               res_in.send_kind = K_DATA;
               res_in.send_block = exp_inc;
               res_in.send_payload_len = ev.got;
            end
         end
         OP_ABORT: begin
            if (busy) phase_in = PH_ABORT;
         end
         default: ;
      endcase
      case (phase_in)
         PH_WAIT, PH_WANT: res_in.status = ST_BUSY;
         PH_DONE: res_in.status = ST_DONE;
         PH_TIMEOUT: res_in.status = ST_TIMEOUT;
         PH_SERR: res_in.status = ST_SERR;
         PH_ABORT: res_in.status = ST_ABORT;
         default: res_in.status = ST_IDLE;
      endcase
      res_in.total_bytes = total_in;
   end

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE; is_put_ff <= 1'b0; peer_known_ff <= 1'b0;
         peer_ff <= server_id; exp_ff <= '0; tries_ff <= '0; tick_ff <= '0;
         lkind_ff <= '0; lblock_ff <= '0; llen_ff <= '0; final_ff <= 1'b0;
         total_ff <= '0; valid_ff <= 1'b0;
      end else begin
         if (take) begin
            phase_ff <= phase_in; is_put_ff <= is_put_in; peer_known_ff <= peer_known_in;
            peer_ff <= peer_in; exp_ff <= exp_in; tries_ff <= tries_in; tick_ff <= tick_in;
            lkind_ff <= lkind_in; lblock_ff <= lblock_in; llen_ff <= llen_in;
            final_ff <= final_in; total_ff <= total_in;
         end
         if (ev_ready) valid_ff <= ev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (take) res_ff <= res_in;
   end
endmodule
`default_nettype wire
